>>> design/uvs_pkg.sv
// Shared types and constants for the UV sphere vertex generator.
// No dependencies.
package uvs_pkg;

  localparam int ATAN_LEN = 24;
  localparam int CORNERS = 6;
  localparam logic [2:0] LAST_CORNER = 3'(CORNERS - 1);
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  // Configuration register indexes.
  typedef enum logic {
    REG_RADIUS = 1'b0,
    REG_RES    = 1'b1
  } reg_idx_e;

  // Side-band that travels with every vertex beat.
  typedef struct packed {
    logic [2:0] corner;
    logic       last;
    logic       err;
  } ctl_t;

  // Arctangent of 2^-i in phase units (2^32 = one turn).
  function automatic logic [31:0] cordic_atan(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004757;
      4:  r = 32'd42667332;
      5:  r = 32'd21354465;
      6:  r = 32'd10679839;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Corner offsets, triangle order (0,0),(1,0),(0,1),(0,1),(1,0),(1,1).
  function automatic logic corner_dlon(input logic [2:0] k);
    logic r;
    case (k)
      3'd1, 3'd4, 3'd5: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic corner_dlat(input logic [2:0] k);
    logic r;
    case (k)
      3'd2, 3'd3, 3'd5: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> design/uv_sphere_vertex_generator.sv
// UV sphere vertex generator: divider, CORDIC and product pipeline.
// Depends on uvs_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one grid cell per beat.
//   Output channel (out_valid_o / out_stall_i) carries one vertex per beat:
//   six beats per cell, corner_index 0..5, last_vertex on the sixth. A cell
//   outside the grid gives a single beat with cell_error and last_vertex set
//   and all other fields zero.
//   Configuration (cfg_we_i, cfg_idx_i, cfg_data_i): index 0 is the radius,
//   index 1 the grid resolution. Write only while the block is empty.
// Timing:
//   A corner sequencer feeds one vertex per cycle into the pipeline while
//   the output is not stalled; a new cell is taken as the last corner (or
//   the single error beat) of the previous cell issues. The pipeline has
//   17 restoring divider stages, one quadrant stage, one stage per CORDIC
//   rotation, quadrant map, three product stages and the output register.
// Reset clears the sequencer and all valid bits; radius returns to 1.0 and
// resolution to 16. When out_stall_i holds a full output register the whole
// pipeline freezes and in_stall_o rises; nothing is dropped or repeated.
module uv_sphere_vertex_generator #(
  parameter int MAX_RESOLUTION = 256,
  parameter int CORDIC_STEPS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          cell_lon_i,
  input  logic [7:0]          cell_lat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [16:0]  pos_x_o,
  output logic signed [16:0]  pos_y_o,
  output logic signed [16:0]  pos_z_o,
  output logic [16:0]         tex_u_o,
  output logic [16:0]         tex_v_o,
  output logic [2:0]          corner_index_o,
  output logic                last_vertex_o,
  output logic                cell_error_o
);

  localparam int STEPS = (CORDIC_STEPS > uvs_pkg::ATAN_LEN) ? uvs_pkg::ATAN_LEN : CORDIC_STEPS;
  localparam int QB    = 17;          // quotient bits
  localparam int NW    = 26;          // numerator / remainder width
  localparam int PST   = QB;          // quadrant stage index
  localparam int CST   = QB + 1;      // first CORDIC stage
  localparam int MST   = CST + STEPS; // quadrant map
  localparam int AST   = MST + 1;     // first products
  localparam int BST   = AST + 1;     // rounding of first products
  localparam int XST   = BST + 1;     // radius products
  localparam int OST   = XST + 1;     // output register
  localparam int L     = OST + 1;
  localparam int UVL   = L - PST - 1;

  localparam logic [8:0] REG_RES_RST = 9'd16;

  // ---------------- configuration ----------------
  logic [15:0] radius_q;
  logic [8:0]  grid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd256;
      grid_q   <= REG_RES_RST;
    end else if (cfg_we_i) begin
      unique case (uvs_pkg::reg_idx_e'(cfg_idx_i))
        uvs_pkg::REG_RADIUS: radius_q <= cfg_data_i;
        uvs_pkg::REG_RES:    grid_q   <= cfg_data_i[8:0];
        default:    ;
      endcase
    end
  end

  logic [8:0] res;
  assign res = (int'(grid_q) > MAX_RESOLUTION) ? 9'(MAX_RESOLUTION) : grid_q;

  // ---------------- corner sequencer ----------------
  logic       vld_q [L];
  logic       adv, accept, last_iss, in_err;
  logic       busy_q, err_q;
  logic [2:0] cnt_q;
  logic [7:0] lon_q, lat_q;

  assign adv      = !vld_q[L-1] || !out_stall_i;
  assign last_iss = err_q || (cnt_q == uvs_pkg::LAST_CORNER);
  assign in_stall_o = !adv || (busy_q && !last_iss);
  assign accept   = in_valid_i && !in_stall_o;
  assign in_err   = (res == 9'd0) || ({1'b0, cell_lon_i} >= res) ||
                    ({1'b0, cell_lat_i} >= res);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
      err_q  <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
      cnt_q  <= 3'd0;
      err_q  <= in_err;
    end else if (adv && busy_q) begin
      if (last_iss) begin
        busy_q <= 1'b0;
        cnt_q  <= 3'd0;
      end else begin
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lon_q <= cell_lon_i;
      lat_q <= cell_lat_i;
    end
  end

  uvs_pkg::ctl_t iss_ctl;
  logic [8:0]    pt_lon, pt_lat;
  logic [NW-1:0] num_u, num_v, div_base;

  always_comb begin
    iss_ctl.corner = cnt_q;
    iss_ctl.last   = last_iss;
    iss_ctl.err    = err_q;
    pt_lon = {1'b0, lon_q} + {8'd0, uvs_pkg::corner_dlon(cnt_q)};
    pt_lat = {1'b0, lat_q} + {8'd0, uvs_pkg::corner_dlat(cnt_q)};
    num_u  = {1'b0, pt_lon, 16'd0} + {17'd0, res >> 1};
    num_v  = {1'b0, pt_lat, 16'd0} + {17'd0, res >> 1};
    div_base = {1'b0, res, 16'd0};
  end

  // ---------------- valid and side-band line ----------------
  uvs_pkg::ctl_t ctl_q [L];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < L; s++) vld_q[s] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= busy_q;
      for (int s = 1; s < L; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl_q[0] <= iss_ctl;
      for (int s = 1; s < L; s++) ctl_q[s] <= ctl_q[s-1];
    end
  end

  // ---------------- restoring dividers, one quotient bit per stage ----------------
  logic [NW-1:0] rem_u_q [QB];
  logic [NW-1:0] rem_v_q [QB];
  logic [QB-1:0] quo_u_q [QB];
  logic [QB-1:0] quo_v_q [QB];

  for (genvar s = 0; s < QB; s++) begin : g_div
    logic [NW-1:0] ru, rv, dv;
    logic [QB-1:0] qu, qv;
    assign dv = div_base >> s;
    if (s == 0) begin : g_first
      assign ru = num_u;
      assign rv = num_v;
      assign qu = '0;
      assign qv = '0;
    end else begin : g_next
      assign ru = rem_u_q[s-1];
      assign rv = rem_v_q[s-1];
      assign qu = quo_u_q[s-1];
      assign qv = quo_v_q[s-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_u_q[s] <= (ru >= dv) ? ru - dv : ru;
        rem_v_q[s] <= (rv >= dv) ? rv - dv : rv;
        quo_u_q[s] <= qu | ((ru >= dv) ? (QB'(1) << (QB - 1 - s)) : '0);
        quo_v_q[s] <= qv | ((rv >= dv) ? (QB'(1) << (QB - 1 - s)) : '0);
      end
    end
  end

  // texture coordinates ride along from the quadrant stage onward
  logic [16:0] tu_q [UVL];
  logic [16:0] tv_q [UVL];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tu_q[0] <= quo_u_q[QB-1];
      tv_q[0] <= quo_v_q[QB-1];
      for (int k = 1; k < UVL; k++) begin
        tu_q[k] <= tu_q[k-1];
        tv_q[k] <= tv_q[k-1];
      end
    end
  end

  // ---------------- quadrant split ----------------
  logic [31:0] ph_l, ph_v, ph_lr, ph_vr;
  logic [1:0]  ql_q, qv_q;
  logic signed [31:0] zl_q, zv_q;

  assign ph_l  = {quo_u_q[QB-1][15:0], 16'd0};
  assign ph_v  = {quo_v_q[QB-1][16:0], 15'd0};
  assign ph_lr = ph_l + 32'h2000_0000;
  assign ph_vr = ph_v + 32'h2000_0000;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ql_q <= ph_lr[31:30];
      qv_q <= ph_vr[31:30];
      zl_q <= $signed(ph_l - {ph_lr[31:30], 30'd0});
      zv_q <= $signed(ph_v - {ph_vr[31:30], 30'd0});
    end
  end

  // ---------------- CORDIC rotations ----------------
  logic signed [33:0] xl_q [STEPS];
  logic signed [33:0] yl_q [STEPS];
  logic signed [33:0] zzl_q [STEPS];
  logic signed [33:0] xv_q [STEPS];
  logic signed [33:0] yv_q [STEPS];
  logic signed [33:0] zzv_q [STEPS];
  logic [1:0]         cql_q [STEPS];
  logic [1:0]         cqv_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    logic signed [33:0] xli, yli, zli, xvi, yvi, zvi, at;
    logic [1:0]         qli, qvi;
    assign at = $signed({2'b00, uvs_pkg::cordic_atan(i)});
    if (i == 0) begin : g_first
      assign xli = uvs_pkg::CORDIC_GAIN;
      assign yli = '0;
      assign zli = {{2{zl_q[31]}}, zl_q};
      assign xvi = uvs_pkg::CORDIC_GAIN;
      assign yvi = '0;
      assign zvi = {{2{zv_q[31]}}, zv_q};
      assign qli = ql_q;
      assign qvi = qv_q;
    end else begin : g_next
      assign xli = xl_q[i-1];
      assign yli = yl_q[i-1];
      assign zli = zzl_q[i-1];
      assign xvi = xv_q[i-1];
      assign yvi = yv_q[i-1];
      assign zvi = zzv_q[i-1];
      assign qli = cql_q[i-1];
      assign qvi = cqv_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        cql_q[i] <= qli;
        cqv_q[i] <= qvi;
        if (!zli[33]) begin
          xl_q[i]  <= xli - (yli >>> i);
          yl_q[i]  <= yli + (xli >>> i);
          zzl_q[i] <= zli - at;
        end else begin
          xl_q[i]  <= xli + (yli >>> i);
          yl_q[i]  <= yli - (xli >>> i);
          zzl_q[i] <= zli + at;
        end
        if (!zvi[33]) begin
          xv_q[i]  <= xvi - (yvi >>> i);
          yv_q[i]  <= yvi + (xvi >>> i);
          zzv_q[i] <= zvi - at;
        end else begin
          xv_q[i]  <= xvi + (yvi >>> i);
          yv_q[i]  <= yvi - (xvi >>> i);
          zzv_q[i] <= zvi + at;
        end
      end
    end
  end

  // ---------------- clamp and quadrant map ----------------
  function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
    logic signed [33:0] r;
    if (v > uvs_pkg::ONE_Q30) r = uvs_pkg::ONE_Q30;
    else if (v < -uvs_pkg::ONE_Q30) r = -uvs_pkg::ONE_Q30;
    else r = v;
    return r[31:0];
  endfunction

  logic signed [31:0] kxl, kyl, kxv, kyv;
  logic signed [31:0] clon_q, slon_q, clat_q, slat_q;

  assign kxl = clamp_unit(xl_q[STEPS-1]);
  assign kyl = clamp_unit(yl_q[STEPS-1]);
  assign kxv = clamp_unit(xv_q[STEPS-1]);
  assign kyv = clamp_unit(yv_q[STEPS-1]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      case (cql_q[STEPS-1])
        2'd0:    begin clon_q <= kxl;  slon_q <= kyl;  end
        2'd1:    begin clon_q <= -kyl; slon_q <= kxl;  end
        2'd2:    begin clon_q <= -kxl; slon_q <= -kyl; end
        default: begin clon_q <= kyl;  slon_q <= -kxl; end
      endcase
      case (cqv_q[STEPS-1])
        2'd0:    begin clat_q <= kxv;  slat_q <= kyv;  end
        2'd1:    begin clat_q <= -kyv; slat_q <= kxv;  end
        2'd2:    begin clat_q <= -kxv; slat_q <= -kyv; end
        default: begin clat_q <= kyv;  slat_q <= -kxv; end
      endcase
    end
  end

  // ---------------- products and rounding ----------------
  logic signed [16:0] rad_s;
  logic signed [63:0] pcx_q, pcy_q;
  logic signed [48:0] pz_q;
  logic signed [31:0] tx_q, ty_q;
  logic signed [16:0] rz_q, rz2_q;
  logic signed [48:0] px_q, py_q;
  logic signed [63:0] rcx, rcy;
  logic signed [48:0] rcz, rpx, rpy;

  assign rad_s = $signed({1'b0, radius_q});
  assign rcx = pcx_q + 64'sd536870912;
  assign rcy = pcy_q + 64'sd536870912;
  assign rcz = pz_q + 49'sd536870912;
  assign rpx = px_q + 49'sd536870912;
  assign rpy = py_q + 49'sd536870912;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pcx_q <= clon_q * slat_q;
      pcy_q <= slon_q * slat_q;
      pz_q  <= rad_s * clat_q;
      tx_q  <= rcx[61:30];
      ty_q  <= rcy[61:30];
      rz_q  <= rcz[46:30];
      px_q  <= rad_s * tx_q;
      py_q  <= rad_s * ty_q;
      rz2_q <= rz_q;
    end
  end

  // ---------------- output register ----------------
  logic signed [16:0] ox_q, oy_q, oz_q;
  logic [16:0]        ou_q, ov_q;
  logic               xerr;

  assign xerr = ctl_q[XST].err;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ox_q <= xerr ? '0 : rpx[46:30];
      oy_q <= xerr ? '0 : rpy[46:30];
      oz_q <= xerr ? '0 : rz2_q;
      ou_q <= xerr ? '0 : tu_q[UVL-1];
      ov_q <= xerr ? '0 : tv_q[UVL-1];
    end
  end

  assign out_valid_o    = vld_q[OST];
  assign pos_x_o        = ox_q;
  assign pos_y_o        = oy_q;
  assign pos_z_o        = oz_q;
  assign tex_u_o        = ou_q;
  assign tex_v_o        = ov_q;
  assign corner_index_o = ctl_q[OST].err ? 3'd0 : ctl_q[OST].corner;
  assign last_vertex_o  = ctl_q[OST].last;
  assign cell_error_o   = ctl_q[OST].err;

`ifndef SYNTHESIS
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cell_error_o |-> last_vertex_o)
    else $error("error beat without last flag");

  a_last_on_sixth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cell_error_o |-> last_vertex_o == (corner_index_o == uvs_pkg::LAST_CORNER))
    else $error("last flag not on sixth corner");

  a_seq_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !last_iss |-> in_stall_o)
    else $error("input taken mid-cell");

  a_pipe_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ctl_q[OST]))
    else $error("output beat lost under stall");
`endif

endmodule

>>> bench/tb_uv_sphere_vertex_generator.sv
// Self-checking bench for uv_sphere_vertex_generator: cell beats in, vertex beats checked
// against an in-bench fixed-point CORDIC predictor. Depends on uvs_pkg and the RTL.
module tb_uv_sphere_vertex_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RES   = 256;
  localparam int STEPS     = 16;
  localparam int DRAIN_CYC = STEPS + 40;
  localparam int LIMIT_CYC = 400000;

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic signed [16:0] z;
    logic [16:0]        u;
    logic [16:0]        v;
    uvs_pkg::ctl_t      ctl;
  } vertex_t;

  class vertex_scoreboard;
    vertex_t    pending[$];
    longint     radius = 256;
    longint     res = 16;
    int         errors = 0;
    int         vertices = 0;
    int         bad_cells = 0;
    int         cells = 0;
    longint     arctan[24] = '{536870912, 316933406, 167458907, 85004757, 42667332,
                               21354465, 10679839, 5340245, 2670163, 1335087, 667544,
                               333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608,
                               1304, 652, 326, 163, 81};

    function void set_reg(logic idx, logic [15:0] d);
      if (idx == uvs_pkg::REG_RADIUS) radius = d;
      else res = d[8:0];
    endfunction

    function longint clamp1(longint a);
      if (a > 64'sd1073741824) return 64'sd1073741824;
      if (a < -64'sd1073741824) return -64'sd1073741824;
      return a;
    endfunction

    // phase: 2^32 is one turn; returns Q30 cos and sin
    function void sincos(longint phase, output longint c, output longint s);
      longint quad, z, cx, cy, nx;
      int n;
      quad = ((phase + 64'sh2000_0000) >>> 30) & 64'sd3;
      z = phase - quad * 64'sh4000_0000;
      if (z >= 64'sh8000_0000) z -= 64'sh1_0000_0000;
      cx = 652032875;
      cy = 0;
      n = (STEPS > 24) ? 24 : STEPS;
      for (int i = 0; i < n; i++) begin
        if (z >= 0) begin
          nx = cx - (cy >>> i);
          cy = cy + (cx >>> i);
          z -= arctan[i];
        end else begin
          nx = cx + (cy >>> i);
          cy = cy - (cx >>> i);
          z += arctan[i];
        end
        cx = nx;
      end
      cx = clamp1(cx);
      cy = clamp1(cy);
      case (quad)
        0: begin c = cx;  s = cy;  end
        1: begin c = -cy; s = cx;  end
        2: begin c = -cx; s = -cy; end
        default: begin c = cy; s = -cx; end
      endcase
    endfunction

    function longint rnd30(longint p);
      return (p + 64'sd536870912) >>> 30;
    endfunction

    function void note_cell(logic [7:0] lon, logic [7:0] lat);
      vertex_t e;
      longint r, u, v, clon, slon, clat, slat;
      int dlon[6] = '{0, 1, 0, 0, 1, 1};
      int dlat[6] = '{0, 0, 1, 1, 0, 1};
      r = (res > MAX_RES) ? MAX_RES : res;
      cells++;
      if (r == 0 || lon >= r || lat >= r) begin
        e = '0;
        e.ctl.last = 1'b1;
        e.ctl.err = 1'b1;
        pending.push_back(e);
        bad_cells++;
        return;
      end
      for (int k = 0; k < 6; k++) begin
        u = ((lon + dlon[k]) * 65536 + r / 2) / r;
        v = ((lat + dlat[k]) * 65536 + r / 2) / r;
        sincos((u << 16) & 64'hFFFF_FFFF, clon, slon);
        sincos((v << 15) & 64'hFFFF_FFFF, clat, slat);
        e.x = 17'(rnd30(radius * rnd30(clon * slat)));
        e.y = 17'(rnd30(radius * rnd30(slon * slat)));
        e.z = 17'(rnd30(radius * clat));
        e.u = u[16:0];
        e.v = v[16:0];
        e.ctl.corner = 3'(k);
        e.ctl.last = (k == uvs_pkg::CORNERS - 1);
        e.ctl.err = 1'b0;
        pending.push_back(e);
      end
    endfunction

    function void field(string name, longint e, longint a);
      if (e != a) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, e, a);
      end
    endfunction

    function void check(vertex_t a);
      vertex_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected vertex beat: expected none, got %h", $time, a);
        return;
      end
      e = pending.pop_front();
      vertices++;
      field("pos_x", e.x, a.x);
      field("pos_y", e.y, a.y);
      field("pos_z", e.z, a.z);
      field("tex_u", e.u, a.u);
      field("tex_v", e.v, a.v);
      field("corner_index", e.ctl.corner, a.ctl.corner);
      field("last_vertex", e.ctl.last, a.ctl.last);
      field("cell_error", e.ctl.err, a.ctl.err);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] cell_lon_i = '0;
  logic [7:0] cell_lat_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [16:0] pos_x_o, pos_y_o, pos_z_o;
  logic [16:0] tex_u_o, tex_v_o;
  logic [2:0] corner_index_o;
  logic last_vertex_o, cell_error_o;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycle_count = 0;
  vertex_scoreboard sb = new();

  uv_sphere_vertex_generator #(
    .MAX_RESOLUTION(MAX_RES),
    .CORDIC_STEPS(STEPS)
  ) uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .cell_lon_i, .cell_lat_i,
    .out_valid_o, .out_stall_i, .pos_x_o, .pos_y_o, .pos_z_o,
    .tex_u_o, .tex_v_o, .corner_index_o, .last_vertex_o, .cell_error_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side: check accepted beats, then pick next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check({pos_x_o, pos_y_o, pos_z_o, tex_u_o, tex_v_o,
                uvs_pkg::ctl_t'{corner_index_o, last_vertex_o, cell_error_o}});
    end
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYC) begin
      $display("timeout after %0d cycles, %0d vertices pending", cycle_count,
               sb.pending.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic cfg_write(logic idx, logic [15:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, d);
  endtask

  task automatic send_cell(logic [7:0] lon, logic [7:0] lat);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cell_lon_i <= lon;
    cell_lat_i <= lat;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_cell(lon, lat);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic configure(logic [15:0] rad, logic [15:0] r);
    drain();
    cfg_write(uvs_pkg::REG_RADIUS, rad);
    cfg_write(uvs_pkg::REG_RES, r);
  endtask

  task automatic random_cells(int n);
    longint r;
    logic [7:0] lon, lat;
    for (int i = 0; i < n; i++) begin
      r = (sb.res > MAX_RES) ? MAX_RES : sb.res;
      if (r > 0 && $urandom_range(99) < 85) begin
        lon = 8'($urandom_range(r - 1));
        lat = 8'($urandom_range(r - 1));
      end else begin
        lon = 8'($urandom);
        lat = 8'($urandom);
      end
      send_cell(lon, lat);
    end
  endtask

  function automatic logic [15:0] pick_res();
    case ($urandom_range(5))
      0: return 16'd1;
      1: return 16'd2;
      2: return 16'd256;
      3: return 16'($urandom_range(3, 16));
      default: return 16'($urandom_range(1, 256));
    endcase
  endfunction

  function automatic logic [15:0] pick_radius();
    case ($urandom_range(4))
      0: return 16'hFFFF;
      1: return 16'd0;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: radius 1.0, 16 cells
    send_cell(8'd0, 8'd0);
    send_cell(8'd15, 8'd15);
    send_cell(8'd16, 8'd0);
    send_cell(8'd0, 8'd16);
    send_cell(8'd255, 8'd255);
    configure(16'hFFFF, 16'd256);
    send_cell(8'd255, 8'd255);
    send_cell(8'd0, 8'd255);
    send_cell(8'd128, 8'd64);
    send_cell(8'd170, 8'd85);
    configure(16'd0, 16'd1);
    send_cell(8'd0, 8'd0);
    send_cell(8'd1, 8'd0);
    send_cell(8'd0, 8'd1);
    configure(16'd256, 16'd0);            // zero grid: every cell is bad
    send_cell(8'd0, 8'd0);
    configure(16'd777, 16'd300);          // saturates to the max grid
    send_cell(8'd255, 8'd0);
    send_cell(8'd3, 8'd254);
    configure(16'd12345, 16'd511);
    send_cell(8'd100, 8'd200);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 65 : 0;
      rx_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 9 : 0;
      for (int s = 0; s < 4; s++) begin
        configure(pick_radius(), pick_res());
        random_cells(15);
        if (ph == 1 && s == 2) drain();   // hold input until empty, then resume
        random_cells(15);
      end
    end

    drain();
    $display("%0d cells (%0d out of grid), %0d vertex beats checked, %0d mismatches",
             sb.cells, sb.bad_cells, sb.vertices, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
